/* sv/fresnel_cosine_rational_approx_assert.svh */
// assertion macros, clocked on aclk and disabled while aresetn is low
`ifndef FRESNEL_COSINE_RATIONAL_APPROX_ASSERT_SVH
`define FRESNEL_COSINE_RATIONAL_APPROX_ASSERT_SVH

// same-cycle implication
`define FCA_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCA_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/fca_pkg.sv */
package fca_pkg;

    localparam int FRAC_BITS_DEF = 23;
    localparam int CQ            = 30;
    localparam int ACC_W         = 34;
    localparam int T_W           = 32;
    localparam int PROD_W        = ACC_W + T_W;

    typedef logic signed [ACC_W-1:0] acc_t;

    // horner stage contents
    typedef struct packed {
        logic                   valid;
        logic                   clamp;
        logic signed [T_W-1:0]  t;
        acc_t                   num;
        acc_t                   den;
    } hstage_t;

    // divider control
    typedef struct packed {
        logic valid;
        logic clamp;
        logic neg;
        logic zero;
        logic ovf;
    } dctl_t;

    // coefficients in Q.30, rounded to nearest
    localparam acc_t NUM_COEF [12] = '{
        acc_t'( ((64'd445261176 << CQ) + 64'd1000000000 / 2) / 64'd1000000000),
        acc_t'(-(((64'd833340366 << CQ) + 64'd1000000000 / 2) / 64'd1000000000)),
        acc_t'( ((64'd846804130 << CQ) + 64'd1000000000 / 2) / 64'd1000000000),
        acc_t'(-(((64'd761239227 << CQ) + 64'd10000000000 / 2) / 64'd10000000000)),
        acc_t'(-(((64'd123292123 << CQ) + 64'd1000000000 / 2) / 64'd1000000000)),
        acc_t'(-(((64'd604190310 << CQ) + 64'd100000000000 / 2) / 64'd100000000000)),
        acc_t'( ((64'd631328855 << CQ) + 64'd100000000000 / 2) / 64'd100000000000),
        acc_t'( ((64'd418803629 << CQ) + 64'd100000000000 / 2) / 64'd100000000000),
        acc_t'( ((64'd127358446 << CQ) + 64'd1000000000000 / 2) / 64'd1000000000000),
        acc_t'(-(((64'd103636686 << CQ) + 64'd1000000000000 / 2) / 64'd1000000000000)),
        acc_t'(-(((64'd572097910 << CQ) + 64'd10000000000000 / 2) / 64'd10000000000000)),
        acc_t'(-(((64'd530165429 << CQ) + 64'd100000000000000 / 2) / 64'd100000000000000))
    };

    localparam acc_t DEN_COEF [9] = '{
        acc_t'(64'd1 << CQ),
        acc_t'(-(((64'd834118536 << CQ) + 64'd1000000000 / 2) / 64'd1000000000)),
        acc_t'( ((64'd530188735 << CQ) + 64'd1000000000 / 2) / 64'd1000000000),
        acc_t'(-(((64'd214818757 << CQ) + 64'd1000000000 / 2) / 64'd1000000000)),
        acc_t'( ((64'd736733694 << CQ) + 64'd10000000000 / 2) / 64'd10000000000),
        acc_t'(-(((64'd181924949 << CQ) + 64'd10000000000 / 2) / 64'd10000000000)),
        acc_t'( ((64'd388704413 << CQ) + 64'd100000000000 / 2) / 64'd100000000000),
        acc_t'(-(((64'd532263839 << CQ) + 64'd1000000000000 / 2) / 64'd1000000000000)),
        acc_t'( ((64'd617737359 << CQ) + 64'd10000000000000 / 2) / 64'd10000000000000)
    };

    // product / 2^30, half away from zero
    function automatic acc_t rnd_q30(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] s;
        mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        s   = (mag + (PROD_W'(1) << (CQ - 1))) >> CQ;
        return p[PROD_W-1] ? acc_t'(-s) : acc_t'(s);
    endfunction

endpackage

/* sv/fca_horner_step.sv */
module fca_horner_step import fca_pkg::*; #(
    parameter acc_t NUM_C  = '0,
    parameter acc_t DEN_C  = '0,
    parameter bit   DEN_ON = 1'b0
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  hstage_t d_in,
    output hstage_t d_out
);

    hstage_t                   mid_reg;
    logic signed [PROD_W-1:0]  prod_n_reg;
    logic signed [PROD_W-1:0]  prod_d_reg;
    hstage_t                   out_reg;
    hstage_t                   out_next;

    // multiply
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg.valid <= 1'b0;
        end else if (en) begin
            mid_reg    <= d_in;
            prod_n_reg <= PROD_W'(d_in.num) * PROD_W'(d_in.t);
            prod_d_reg <= PROD_W'(d_in.den) * PROD_W'(d_in.t);
        end
    end

    // round and add coefficient
    always_comb begin
        out_next     = mid_reg;
        out_next.num = NUM_C + rnd_q30(prod_n_reg);
        if (DEN_ON) begin
            out_next.den = DEN_C + rnd_q30(prod_d_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (en) begin
            out_reg <= out_next;
        end
    end

    assign d_out = out_reg;

endmodule

/* sv/fca_div_prep.sv */
module fca_div_prep import fca_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int N_W       = FRAC_BITS + ACC_W + 1,
    parameter int R_W       = ACC_W + 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  hstage_t          h_in,
    output dctl_t            ctl_out,
    output logic [N_W-1:0]   n_out,
    output logic [ACC_W-1:0] d_out,
    output logic [R_W-1:0]   r_out
);

    dctl_t             a_ctl_reg;
    logic [N_W-1:0]    a_n_reg;
    logic [ACC_W-1:0]  a_d_reg;
    logic [ACC_W-1:0]  mag;
    dctl_t             b_ctl_reg;
    dctl_t             b_ctl_next;
    logic [N_W-1:0]    b_n_reg;
    logic [ACC_W-1:0]  b_d_reg;
    logic [R_W-1:0]    b_r_reg;
    logic [N_W-1:0]    n_hi;

    assign mag = h_in.num[ACC_W-1] ? ACC_W'(-h_in.num) : ACC_W'(h_in.num);

    // scaled dividend plus half divisor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_ctl_reg.valid <= 1'b0;
        end else if (en) begin
            a_ctl_reg.valid <= h_in.valid;
            a_ctl_reg.clamp <= h_in.clamp;
            a_ctl_reg.neg   <= h_in.num[ACC_W-1];
            a_ctl_reg.zero  <= (h_in.den <= 0);
            a_ctl_reg.ovf   <= 1'b0;
            a_n_reg <= (N_W'(mag) << FRAC_BITS) + N_W'(ACC_W'(h_in.den) >> 1);
            a_d_reg <= ACC_W'(h_in.den);
        end
    end

    assign n_hi = a_n_reg >> (FRAC_BITS + 2);

    // quotient overflow when the top bits already reach the divisor
    always_comb begin
        b_ctl_next     = a_ctl_reg;
        b_ctl_next.ovf = (n_hi >= N_W'(a_d_reg));
    end

    // quotient overflow check and starting remainder
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_ctl_reg.valid <= 1'b0;
        end else if (en) begin
            b_ctl_reg <= b_ctl_next;
            b_n_reg   <= a_n_reg;
            b_d_reg   <= a_d_reg;
            b_r_reg   <= R_W'(n_hi);
        end
    end

    assign ctl_out = b_ctl_reg;
    assign n_out   = b_n_reg;
    assign d_out   = b_d_reg;
    assign r_out   = b_r_reg;

endmodule

/* sv/fca_div_stage.sv */
module fca_div_stage import fca_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int BIT       = 0,
    parameter int N_W       = FRAC_BITS + ACC_W + 1,
    parameter int R_W       = ACC_W + 1,
    parameter int Q_W       = FRAC_BITS + 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  dctl_t            ctl_in,
    input  logic [N_W-1:0]   n_in,
    input  logic [ACC_W-1:0] d_in,
    input  logic [R_W-1:0]   r_in,
    input  logic [Q_W-1:0]   q_in,
    output dctl_t            ctl_out,
    output logic [N_W-1:0]   n_out,
    output logic [ACC_W-1:0] d_out,
    output logic [R_W-1:0]   r_out,
    output logic [Q_W-1:0]   q_out
);

    dctl_t             ctl_reg;
    logic [N_W-1:0]    n_reg;
    logic [ACC_W-1:0]  d_reg;
    logic [R_W-1:0]    r_reg;
    logic [Q_W-1:0]    q_reg;
    logic [R_W-1:0]    r_shift;
    logic              geq;
    logic [R_W-1:0]    r_next;

    // one restoring step
    assign r_shift = {r_in[R_W-2:0], n_in[BIT]};
    assign geq     = (r_shift >= R_W'(d_in));
    assign r_next  = geq ? (r_shift - R_W'(d_in)) : r_shift;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg <= ctl_in;
            n_reg   <= n_in;
            d_reg   <= d_in;
            r_reg   <= r_next;
            q_reg   <= {q_in[Q_W-2:0], geq};
        end
    end

    assign ctl_out = ctl_reg;
    assign n_out   = n_reg;
    assign d_out   = d_reg;
    assign r_out   = r_reg;
    assign q_out   = q_reg;

endmodule

/* sv/fresnel_cosine_rational_approx.sv */
// throughput: one argument per cycle while the skid is not full; set by the fully pipelined horner and divider chain
// horner takes two stages per step (multiply, round-add), divider one stage per quotient bit
// a two-entry output skid lets one more argument enter while a result waits
// aresetn is synchronous, active low; it clears all valid bits and the skid, no data reset
`include "fresnel_cosine_rational_approx_assert.svh"

module fresnel_cosine_rational_approx import fca_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [FRAC_BITS+1:0]  s_x_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [FRAC_BITS:0] m_fresnel_c,
    output logic                  m_was_clamped
);

    localparam int X_W   = FRAC_BITS + 2;
    localparam int OUT_W = FRAC_BITS + 1;
    localparam int N_W   = FRAC_BITS + ACC_W + 1;
    localparam int R_W   = ACC_W + 1;
    localparam int Q_W   = FRAC_BITS + 2;
    localparam int NDIV  = FRAC_BITS + 2;

    localparam logic [X_W-1:0] X_LO  = X_W'(1) << FRAC_BITS;
    localparam logic [X_W-1:0] X_HI  = X_W'(1) << (FRAC_BITS + 1);
    localparam logic [X_W-1:0] X_MID = X_W'(3) << (FRAC_BITS - 1);
    localparam logic signed [T_W-1:0] T_MAX = T_W'(1) << CQ;
    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_BITS;
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // global pipeline advance, held only while the skid is full
    logic en;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign en      = (cnt_reg != 2'd2);
    assign s_ready = en;

    // clamp and map to t = 2(x - 1.5) in Q.30
    logic [X_W-1:0]      x_c;
    logic                clamp;
    logic signed [X_W:0] diff;
    hstage_t             st0_reg;
    hstage_t             st0_next;

    always_comb begin
        x_c   = s_x_in;
        clamp = 1'b0;
        if (s_x_in < X_LO) begin
            x_c   = X_LO;
            clamp = 1'b1;
        end else if (s_x_in > X_HI) begin
            x_c   = X_HI;
            clamp = 1'b1;
        end
        diff           = $signed({1'b0, x_c}) - $signed({1'b0, X_MID});
        st0_next.valid = s_valid;
        st0_next.clamp = clamp;
        st0_next.t     = T_W'(diff) <<< (31 - FRAC_BITS);
        st0_next.num   = NUM_COEF[11];
        st0_next.den   = DEN_COEF[8];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_reg.valid <= 1'b0;
        end else if (en) begin
            st0_reg <= st0_next;
        end
    end

    // horner chain: numerator over 11 steps, denominator joins for the last 8
    hstage_t hs [12];
    assign hs[0] = st0_reg;

    for (genvar i = 0; i < 11; i++) begin : g_horner
        fca_horner_step #(
            .NUM_C  (NUM_COEF[10-i]),
            .DEN_C  (DEN_COEF[((10-i) <= 7) ? (10-i) : 0]),
            .DEN_ON ((10-i) <= 7)
        ) u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .d_in    (hs[i]),
            .d_out   (hs[i+1])
        );
    end

    // divider: setup, then one quotient bit per stage, msb first
    dctl_t             dc [NDIV+1];
    logic [N_W-1:0]    dn [NDIV+1];
    logic [ACC_W-1:0]  dd [NDIV+1];
    logic [R_W-1:0]    dr [NDIV+1];
    logic [Q_W-1:0]    dq [NDIV+1];

    fca_div_prep #(
        .FRAC_BITS (FRAC_BITS),
        .N_W       (N_W),
        .R_W       (R_W)
    ) u_prep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .h_in    (hs[11]),
        .ctl_out (dc[0]),
        .n_out   (dn[0]),
        .d_out   (dd[0]),
        .r_out   (dr[0])
    );
    assign dq[0] = '0;

    for (genvar j = 0; j < NDIV; j++) begin : g_div
        fca_div_stage #(
            .FRAC_BITS (FRAC_BITS),
            .BIT       (NDIV - 1 - j),
            .N_W       (N_W),
            .R_W       (R_W),
            .Q_W       (Q_W)
        ) u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (dc[j]),
            .n_in    (dn[j]),
            .d_in    (dd[j]),
            .r_in    (dr[j]),
            .q_in    (dq[j]),
            .ctl_out (dc[j+1]),
            .n_out   (dn[j+1]),
            .d_out   (dd[j+1]),
            .r_out   (dr[j+1]),
            .q_out   (dq[j+1])
        );
    end

    // sign, saturation, and the non-positive denominator case
    dctl_t                   fin_ctl;
    logic                    big;
    logic signed [OUT_W-1:0] res;

    assign fin_ctl = dc[NDIV];

    always_comb begin
        big = fin_ctl.ovf || (dq[NDIV] >= Q_ONE);
        if (fin_ctl.zero) begin
            res = '0;
        end else if (fin_ctl.neg) begin
            res = big ? OUT_MIN : OUT_W'(-dq[NDIV]);
        end else begin
            res = big ? OUT_MAX : OUT_W'(dq[NDIV]);
        end
    end

    // two-entry output skid, head in entry 0
    logic                    push;
    logic                    pop;
    logic signed [OUT_W-1:0] e0_c_reg, e0_c_next, e1_c_reg, e1_c_next;
    logic                    e0_cl_reg, e0_cl_next, e1_cl_reg, e1_cl_next;

    assign push = fin_ctl.valid && en;
    assign pop  = m_valid && m_ready;

    always_comb begin
        cnt_next   = cnt_reg;
        e0_c_next  = e0_c_reg;
        e0_cl_next = e0_cl_reg;
        e1_c_next  = e1_c_reg;
        e1_cl_next = e1_cl_reg;
        if (pop) begin
            e0_c_next  = e1_c_reg;
            e0_cl_next = e1_cl_reg;
        end
        if (push) begin
            if ((cnt_reg == 2'd0) || (pop && (cnt_reg == 2'd1))) begin
                e0_c_next  = res;
                e0_cl_next = fin_ctl.clamp;
            end else begin
                e1_c_next  = res;
                e1_cl_next = fin_ctl.clamp;
            end
        end
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        e0_c_reg  <= e0_c_next;
        e0_cl_reg <= e0_cl_next;
        e1_c_reg  <= e1_c_next;
        e1_cl_reg <= e1_cl_next;
    end

    assign m_valid       = (cnt_reg != 2'd0);
    assign m_fresnel_c   = e0_c_reg;
    assign m_was_clamped = e0_cl_reg;

    // t never leaves [-1, 1] after the clamp
    `FCA_CHECK(a_t_range, st0_reg.valid, (st0_reg.t <= T_MAX) && (st0_reg.t >= -T_MAX), "t out of range")
    // the fitted denominator stays positive on [-1, 1]
    `FCA_CHECK(a_den_pos, hs[11].valid, hs[11].den > 0, "denominator not positive")
    // a full skid is never empty in the following cycle
    `FCA_CHECK_NEXT(a_skid_full, cnt_reg == 2'd2, cnt_reg != 2'd0, "skid lost an entry")

endmodule

/* test/fresnel_cosine_rational_approx_checker.sv */
`timescale 1ns / 1ps

module fresnel_cosine_rational_approx_checker #(
    parameter int FRAC_BITS = 23
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [FRAC_BITS+1:0]     s_x_in,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [FRAC_BITS:0] m_fresnel_c,
    input  logic                     m_was_clamped,
    output int                       errors,
    output int                       pending
);
    localparam int QF = 30;

    typedef struct {
        logic signed [FRAC_BITS:0] c;
        logic                      clamp;
    } cos_result_t;

    cos_result_t want_q[$];
    longint num_k[12];
    longint den_k[9];

    function automatic longint to_q30(longint m, longint p, bit neg);
        longint v;
        v = ((m <<< QF) + p / 2) / p;
        return neg ? -v : v;
    endfunction

    function automatic longint div_q30(longint v);
        longint h;
        h = longint'(1) <<< (QF - 1);
        if (v >= 0) return (v + h) >>> QF;
        return -((-v + h) >>> QF);
    endfunction

    function automatic cos_result_t fresnel_predict(logic [FRAC_BITS+1:0] xin);
        cos_result_t r;
        longint x, t, num, den, q, mag, quo;
        longint lo, hi;
        lo = longint'(1) <<< FRAC_BITS;
        hi = longint'(1) <<< (FRAC_BITS + 1);
        x = longint'(xin);
        r.clamp = 1'b0;
        if (x < lo) begin x = lo; r.clamp = 1'b1; end
        if (x > hi) begin x = hi; r.clamp = 1'b1; end
        t = (x - 3 * (longint'(1) <<< (FRAC_BITS - 1))) * (longint'(1) <<< (31 - FRAC_BITS));
        num = num_k[11];
        for (int k = 10; k >= 0; k--) num = num_k[k] + div_q30(num * t);
        den = den_k[8];
        for (int k = 7; k >= 0; k--) den = den_k[k] + div_q30(den * t);
        if (den <= 0) begin
            q = 0;
        end else begin
            mag = num < 0 ? -num : num;
            quo = ((mag <<< FRAC_BITS) + den / 2) / den;
            if (quo > hi) quo = hi;
            q = num < 0 ? -quo : quo;
            if (q > lo - 1) q = lo - 1;
            if (q < -lo) q = -lo;
        end
        r.c = q[FRAC_BITS:0];
        return r;
    endfunction

    initial begin
        num_k = '{to_q30(445261176, 64'd1000000000, 0), to_q30(833340366, 64'd1000000000, 1),
                  to_q30(846804130, 64'd1000000000, 0), to_q30(761239227, 64'd10000000000, 1),
                  to_q30(123292123, 64'd1000000000, 1), to_q30(604190310, 64'd100000000000, 1),
                  to_q30(631328855, 64'd100000000000, 0),
                  to_q30(418803629, 64'd100000000000, 0),
                  to_q30(127358446, 64'd1000000000000, 0),
                  to_q30(103636686, 64'd1000000000000, 1),
                  to_q30(572097910, 64'd10000000000000, 1),
                  to_q30(530165429, 64'd100000000000000, 1)};
        den_k = '{longint'(1) <<< QF, to_q30(834118536, 64'd1000000000, 1),
                  to_q30(530188735, 64'd1000000000, 0), to_q30(214818757, 64'd1000000000, 1),
                  to_q30(736733694, 64'd10000000000, 0), to_q30(181924949, 64'd10000000000, 1),
                  to_q30(388704413, 64'd100000000000, 0),
                  to_q30(532263839, 64'd1000000000000, 1),
                  to_q30(617737359, 64'd10000000000000, 0)};
    end

    always @(posedge aclk) begin
        cos_result_t w;
        if (!aresetn) begin
            errors  <= 0;
            pending <= 0;
        end else begin
            if (s_valid && s_ready) want_q.push_back(fresnel_predict(s_x_in));
            if (m_valid && m_ready) begin
                if (want_q.size() == 0) begin
                    $display("%0t: unexpected result c=%0d clamp=%0b", $time,
                             m_fresnel_c, m_was_clamped);
                    errors <= errors + 1;
                end else begin
                    w = want_q.pop_front();
                    if (w.c !== m_fresnel_c || w.clamp !== m_was_clamped) begin
                        $display("%0t: mismatch expected c=%0d clamp=%0b actual c=%0d clamp=%0b",
                                 $time, w.c, w.clamp, m_fresnel_c, m_was_clamped);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= want_q.size();
        end
    end
endmodule

/* test/fresnel_cosine_rational_approx_tb.sv */
`timescale 1ns / 1ps

module fresnel_cosine_rational_approx_tb;
    import fca_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int XW = FB + 2;
    localparam int N_RANDOM = 900;
    localparam int LIMIT = 400000;

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    logic [XW-1:0] s_x_in;
    logic          m_valid;
    logic          m_ready;
    logic signed [FB:0] m_fresnel_c;
    logic          m_was_clamped;
    int            errors;
    int            pending;
    int            cycle_cnt;
    bit            hold_off;   // long receiver stall for backpressure

    fresnel_cosine_rational_approx #(.FRAC_BITS(FB)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_x_in(s_x_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_fresnel_c(m_fresnel_c), .m_was_clamped(m_was_clamped)
    );

    fresnel_cosine_rational_approx_checker #(.FRAC_BITS(FB)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_x_in(s_x_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_fresnel_c(m_fresnel_c), .m_was_clamped(m_was_clamped),
        .errors(errors), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // watchdog on a cycle counter
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("FAIL fresnel_cosine_rational_approx");
            $finish;
        end
    end

    // receiver: own stall pattern, plus one long hold-off
    initial begin
        int mode;
        m_ready  = 1'b0;
        hold_off = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
            end else begin
                mode = (cycle_cnt / 300) % 3;
                case (mode)
                    0: begin m_ready <= 1'b1; end
                    1: begin m_ready <= ($urandom_range(3) != 0); end
                    default: begin m_ready <= ($urandom_range(1) == 0); end
                endcase
            end
        end
    end

    // long stall counted in its own process, once the pipeline is busy
    initial begin
        @(posedge aclk iff (aresetn && cycle_cnt > 600));
        hold_off = 1'b1;
        repeat (200) @(posedge aclk);
        hold_off = 1'b0;
    end

    // offer one argument and wait for its transfer
    task automatic send_arg(logic [XW-1:0] x);
        s_valid <= 1'b1;
        s_x_in  <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [XW-1:0] rand_arg();
        int sel;
        logic [XW-1:0] lo, hi;
        lo = XW'(1) << FB;
        hi = XW'(1) << (FB + 1);
        sel = $urandom_range(9);
        // mostly in the fitted interval, some outside and near the ends
        if (sel < 7) return lo + XW'($urandom_range(1 << FB));
        if (sel == 7) return XW'($urandom);
        if (sel == 8) return lo + XW'($urandom_range(4)) - XW'(2);
        return hi + XW'($urandom_range(4)) - XW'(2);
    endfunction

    initial begin
        logic [XW-1:0] lo, hi;
        logic [XW-1:0] dir_q[$];
        int sent;
        lo = XW'(1) << FB;
        hi = XW'(1) << (FB + 1);
        cycle_cnt = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_x_in  = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, interval ends, midpoint, clamp both sides
        dir_q = '{'0, XW'(1), lo - XW'(1), lo, lo + XW'(1), lo + (lo >> 1), hi - XW'(1), hi,
                  hi + XW'(1), {XW{1'b1}}, {XW{1'b1}} - XW'(1), XW'(1) << (XW - 1), (lo >> 1),
                  lo + (lo >> 2), lo + XW'(3) * (lo >> 2), XW'(25'h155_5555),
                  XW'(25'h0AA_AAAA)};
        foreach (dir_q[i]) send_arg(dir_q[i]);

        // random bursts with gaps between most of them
        sent = 0;
        while (sent < N_RANDOM) begin
            int burst;
            burst = $urandom_range(40, 1);
            for (int i = 0; i < burst && sent < N_RANDOM; i++) begin
                send_arg(rand_arg());
                sent++;
            end
            if ($urandom_range(3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(8, 1)) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;

        // drain and let the pipeline settle
        while (pending != 0) @(posedge aclk);
        repeat (FB + 40) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS fresnel_cosine_rational_approx");
        end else begin
            $display("FAIL fresnel_cosine_rational_approx");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+sv
sv/fca_pkg.sv
sv/fca_horner_step.sv
sv/fca_div_prep.sv
sv/fca_div_stage.sv
sv/fresnel_cosine_rational_approx.sv
test/fresnel_cosine_rational_approx_checker.sv
test/fresnel_cosine_rational_approx_tb.sv
